@@ src/itda_pkg.sv @@
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int ValueWidth    = 32;
  localparam int CharWidth     = 8;
  localparam int DigitWidth    = 4;
  localparam int MaxDigits     = 10;
  localparam int DigitIdxWidth = $clog2(MaxDigits);
  localparam int QueueDepth    = 2;

  localparam logic [CharWidth-1:0] CharZero  = 8'd48;
  localparam logic [CharWidth-1:0] CharMinus = 8'd45;

  // floor(x / 10) == (x * RecipTen) >> RecipShift for every 32-bit x.
  localparam logic [ValueWidth-1:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int                    RecipShift = 35;

  typedef struct packed {
    logic                  negative;
    logic [ValueWidth-1:0] magnitude;
  } item_t;

endpackage

@@ src/itda_front.sv @@
// ----------------------------------------------------------------------------
// itda_front
// Accepts input transactions, splits each value into sign and magnitude and
// hands the classified item to the queue.
// ----------------------------------------------------------------------------
module itda_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [itda_pkg::ValueWidth-1:0] value,
  output logic                                 busy,
  output logic                                 push,
  output itda_pkg::item_t                      push_item,
  input  logic                                 push_ready
);

  logic                             hold_valid;
  itda_pkg::item_t                  hold_item;
  logic [itda_pkg::ValueWidth-1:0]  value_u;
  itda_pkg::item_t                  classified;

  assign value_u               = $unsigned(value);
  assign classified.negative   = value_u[itda_pkg::ValueWidth-1];
  assign classified.magnitude  = classified.negative ?
                                 (~value_u + itda_pkg::ValueWidth'(1)) : value_u;

  assign busy      = hold_valid && !push_ready;
  assign push      = hold_valid;
  assign push_item = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (start && !busy) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      hold_item <= classified;
    end
  end

endmodule

@@ src/itda_queue.sv @@
// ----------------------------------------------------------------------------
// itda_queue
// Short first-in first-out queue of classified items between the front and
// the back of the converter.
// ----------------------------------------------------------------------------
module itda_queue #(
  parameter int DEPTH = itda_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  itda_pkg::item_t push_item,
  output logic            push_ready,
  input  logic            pop,
  output itda_pkg::item_t pop_item,
  output logic            not_empty
);

  localparam int PtrWidth   = $clog2(DEPTH);
  localparam int CountWidth = $clog2(DEPTH + 1);

  itda_pkg::item_t         entries [DEPTH];
  logic [PtrWidth-1:0]     wr_ptr;
  logic [PtrWidth-1:0]     rd_ptr;
  logic [CountWidth-1:0]   count;
  logic                    do_push;
  logic                    do_pop;

  assign push_ready = (count != CountWidth'(DEPTH));
  assign not_empty  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CountWidth'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ src/itda_back.sv @@
// ----------------------------------------------------------------------------
// itda_back
// Converts one magnitude to decimal digits with a divide-by-ten unit, one
// digit per cycle, then sends the sign and the digits out one per cycle.
// ----------------------------------------------------------------------------
module itda_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               avail,
  input  itda_pkg::item_t                    head,
  output logic                               pop,
  output logic [itda_pkg::CharWidth-1:0]     character,
  output logic                               last,
  output logic                               strobe
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_t;

  localparam int W = itda_pkg::ValueWidth;

  state_t                                state;
  logic                                  negative;
  logic [W-1:0]                          work;
  logic [itda_pkg::DigitIdxWidth-1:0]    ptr;
  logic [itda_pkg::DigitWidth-1:0]       digits [itda_pkg::MaxDigits];

  logic [2*W-1:0]                        product;
  logic [W-1:0]                          quotient;
  logic [W-1:0]                          remainder_full;
  logic [itda_pkg::DigitWidth-1:0]       remainder;

  assign product        = (2*W)'(work) * (2*W)'(itda_pkg::RecipTen);
  assign quotient       = W'(product[2*W-1:itda_pkg::RecipShift]);
  assign remainder_full = work - ((quotient << 3) + (quotient << 1));
  assign remainder      = remainder_full[itda_pkg::DigitWidth-1:0];

  assign pop = (state == StIdle) && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= StIdle;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        StIdle: begin
          if (avail) begin
            negative <= head.negative;
            work     <= head.magnitude;
            ptr      <= '0;
            state    <= StConv;
          end
        end
        StConv: begin
          digits[ptr] <= remainder;
          if (quotient == '0) begin
            state <= StEmit;
          end else begin
            work <= quotient;
            ptr  <= ptr + itda_pkg::DigitIdxWidth'(1);
          end
        end
        StEmit: begin
          strobe <= 1'b1;
          if (negative) begin
            character <= itda_pkg::CharMinus;
            last      <= 1'b0;
            negative  <= 1'b0;
          end else begin
            character <= itda_pkg::CharZero +
                         itda_pkg::CharWidth'(digits[ptr]);
            last      <= (ptr == '0);
            if (ptr == '0) begin
              state <= StIdle;
            end else begin
              ptr <= ptr - itda_pkg::DigitIdxWidth'(1);
            end
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

endmodule

@@ src/int_to_decimal_ascii_core.sv @@
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_core
// Signed 32-bit integer to decimal ASCII text, one character per strobe.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. Its text leaves most
// significant character first, a leading '-' for negative values, one
// character per cycle with strobe high, and last marks the final character.
// The receiver cannot stall, so characters must be captured whenever strobe
// is high. A number occupies the converter while it is loaded, while the
// single divide-by-ten unit produces its digits, one digit per cycle, and
// while its characters leave on the one-character output port. A short
// queue ahead of the converter lets new values be taken while an earlier
// one is still being converted.
module int_to_decimal_ascii_core #(
  parameter int QUEUE_DEPTH = itda_pkg::QueueDepth
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [itda_pkg::ValueWidth-1:0] value,
  output logic                                   busy,
  output logic [itda_pkg::CharWidth-1:0]         character,
  output logic                                   last,
  output logic                                   strobe
);

  logic            push;
  itda_pkg::item_t push_item;
  logic            push_ready;
  logic            pop;
  itda_pkg::item_t pop_item;
  logic            not_empty;

  itda_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .value      (value),
    .busy       (busy),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  itda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_item   (pop_item),
    .not_empty  (not_empty)
  );

  itda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (not_empty),
    .head      (pop_item),
    .pop       (pop),
    .character (character),
    .last      (last),
    .strobe    (strobe)
  );

endmodule
